// ===== hw/rtl/mnfpc_pkg.sv =====
// Shared types and constants for the mesh nearest-face colour lookup.
package mnfpc_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_FACES_DEF    = 1024;
  localparam int MAX_CORNERS_DEF  = 8;

  localparam int CMDW   = 2;
  localparam int IDXW   = 10;
  localparam int CORNW  = 3;
  localparam int SIZEW  = 4;
  localparam int NW     = 5;   // corner count 0..15
  localparam int COORDW = 16;
  localparam int COLW   = 24;
  localparam int FCW    = 11;
  localparam int LIMW   = 15;
  localparam int CFGW   = 15;
  localparam int CFGIW  = 2;
  localparam int KW     = 4;
  localparam int OPAW   = 18;
  localparam int OPBW   = 37;
  localparam int PRODW  = OPAW + OPBW;
  localparam int ACCW   = 56;
  localparam int WW     = 35;
  localparam int ABSW   = 34;

  typedef enum logic [CMDW-1:0] {
    CMD_VERTEX = 2'd0,
    CMD_CORNER = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_code_t;

  typedef enum logic [CFGIW-1:0] {
    CFG_FACE_COUNT  = 2'd0,
    CFG_MAX_INSIDE  = 2'd1,
    CFG_MAX_OUTSIDE = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    MAC_NONE, MAC_D0, MAC_D1, MAC_D2,
    MAC_X0, MAC_X1, MAC_X2, MAC_X3, MAC_X4, MAC_X5,
    MAC_T0, MAC_T1, MAC_T2
  } mac_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FACE, ST_V0, ST_V0L, ST_DIST, ST_DCHK, ST_PC, ST_PV,
    ST_PVL, ST_EC, ST_EV, ST_EL, ST_EMAC, ST_ECHK, ST_ACC, ST_DONE
  } state_t;

  typedef struct packed {
    logic             wr_vertex;
    logic             wr_corner;
    logic             q_load;
    logic             load_p;
    logic             load_u2;
    logic             load_edge;
    logic             dist_chk;
    logic             accept;
    logic             res_load;
    logic [FCW-1:0]   face;
    logic [NW-1:0]    corner_idx;
    mac_op_t          mac;
  } dp_cmd_t;

  typedef struct packed {
    logic [SIZEW-1:0] size;
    logic [FCW-1:0]   count;
    logic             dist_ok;
    logic             edge_out;
    logic             out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/mesh_nearest_face_point_colour.sv =====
// Top level: mesh store and nearest-face colour lookup for a query point.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  cmd, entry, corner, corner_vertex, face_size,
//                                           pos_xyz, normal_xyz, colour_rgb
//  out      source     out_valid/out_stall  hit, red, green, blue
//  cfg      sink       cfg_we               cfg_index, cfg_data
//
// Vertex and corner writes are taken in the idle state; cmd 3 is taken and dropped.
// A query scans the faces in turn, testing each face's plane distance and then its
// edges; the single shared multiply-accumulate forms 3 products per distance
// test and 9 per edge test.
// One item is worked at a time; a finished result sits in the output register
// while writes keep flowing, and a following query waits only to load its result.
// Synchronous active-high reset clears control and config; mesh memories are
// not cleared.
module mesh_nearest_face_point_colour
  import mnfpc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_FACES    = MAX_FACES_DEF,
  parameter int MAX_CORNERS  = MAX_CORNERS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFGIW-1:0]         cfg_index,
  input  logic [CFGW-1:0]          cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMDW-1:0]          cmd,
  input  logic [IDXW-1:0]          entry,
  input  logic [CORNW-1:0]         corner,
  input  logic [IDXW-1:0]          corner_vertex,
  input  logic [SIZEW-1:0]         face_size,
  input  logic signed [COORDW-1:0] pos_x,
  input  logic signed [COORDW-1:0] pos_y,
  input  logic signed [COORDW-1:0] pos_z,
  input  logic signed [COORDW-1:0] normal_x,
  input  logic signed [COORDW-1:0] normal_y,
  input  logic signed [COORDW-1:0] normal_z,
  input  logic [COLW-1:0]          colour_rgb,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     hit,
  output logic [7:0]               red,
  output logic [7:0]               green,
  output logic [7:0]               blue
);

  dp_cmd_t  dp_cmd;
  dp_stat_t stat;

  // sequencer: face loop, edge loop, MAC step count
  mnfpc_ctrl #(.MAX_CORNERS(MAX_CORNERS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat),
    .dp_cmd   (dp_cmd)
  );

  // memories, arithmetic, best-so-far and result register
  mnfpc_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_FACES    (MAX_FACES),
    .MAX_CORNERS  (MAX_CORNERS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .entry         (entry),
    .corner        (corner),
    .corner_vertex (corner_vertex),
    .face_size     (face_size),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .normal_z      (normal_z),
    .colour_rgb    (colour_rgb),
    .dp_cmd        (dp_cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .red           (red),
    .green         (green),
    .blue          (blue)
  );

endmodule

// ===== hw/rtl/mnfpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mnfpc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                     wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                     rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mnfpc_ctrl.sv =====
// Query sequencer: walks faces and edges and drives the datapath.
module mnfpc_ctrl
  import mnfpc_pkg::*;
#(
  parameter int MAX_CORNERS = MAX_CORNERS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [CMDW-1:0] cmd,
  input  dp_stat_t        stat,
  output dp_cmd_t         dp_cmd
);

  state_t          state, state_next;
  logic [FCW-1:0]  f;
  logic [NW-1:0]   n;
  logic [NW-1:0]   i;
  logic [KW-1:0]   k;
  logic            idle_take;

  assign idle_take = (state == ST_IDLE) && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      f     <= '0;
      n     <= '0;
      i     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= ((state == ST_DIST) || (state == ST_EMAC)) ? KW'(k + 1'b1) : '0;
      case (state)
        ST_IDLE: f <= '0;
        ST_V0: begin
          n <= (32'(stat.size) > MAX_CORNERS) ? NW'(MAX_CORNERS) : NW'(stat.size);
          i <= '0;
        end
        ST_DCHK: if (!stat.dist_ok) f <= FCW'(f + 1'b1);
        ST_ECHK: begin
          if (stat.edge_out) f <= FCW'(f + 1'b1);
          else               i <= NW'(i + 1'b1);
        end
        ST_ACC: f <= FCW'(f + 1'b1);
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid && (cmd == CMD_QUERY)) state_next = ST_FACE;
      ST_FACE: state_next = (f == stat.count) ? ST_DONE : ST_V0;
      ST_V0:   state_next = ST_V0L;
      ST_V0L:  state_next = ST_DIST;
      ST_DIST: if (k == KW'(2)) state_next = ST_DCHK;
      ST_DCHK: begin
        if (!stat.dist_ok)   state_next = ST_FACE;
        else if (n == '0)    state_next = ST_ACC;
        else                 state_next = ST_PC;
      end
      ST_PC:   state_next = ST_PV;
      ST_PV:   state_next = ST_PVL;
      ST_PVL:  state_next = ST_EC;
      ST_EC:   state_next = ST_EV;
      ST_EV:   state_next = ST_EL;
      ST_EL:   state_next = ST_EMAC;
      ST_EMAC: if (k == KW'(8)) state_next = ST_ECHK;
      ST_ECHK: begin
        if (stat.edge_out)               state_next = ST_FACE;
        else if (NW'(i + 1'b1) == n)     state_next = ST_ACC;
        else                             state_next = ST_EC;
      end
      ST_ACC:  state_next = ST_FACE;
      ST_DONE: if (stat.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall          = (state != ST_IDLE);
    dp_cmd            = '0;
    dp_cmd.mac        = MAC_NONE;
    dp_cmd.face       = f;
    dp_cmd.wr_vertex  = idle_take && (cmd == CMD_VERTEX);
    dp_cmd.wr_corner  = idle_take && (cmd == CMD_CORNER);
    dp_cmd.q_load     = idle_take && (cmd == CMD_QUERY);
    unique case (state)
      ST_V0L:  dp_cmd.load_p    = 1'b1;
      ST_DIST: begin
        unique case (k)
          KW'(0):  dp_cmd.mac = MAC_D0;
          KW'(1):  dp_cmd.mac = MAC_D1;
          default: dp_cmd.mac = MAC_D2;
        endcase
      end
      ST_DCHK: dp_cmd.dist_chk  = 1'b1;
      ST_PC:   dp_cmd.corner_idx = NW'(n - 1'b1);
      ST_PVL:  dp_cmd.load_u2   = 1'b1;
      ST_EC:   dp_cmd.corner_idx = i;
      ST_EL:   dp_cmd.load_edge = 1'b1;
      ST_EMAC: begin
        unique case (k)
          KW'(0):  dp_cmd.mac = MAC_X0;
          KW'(1):  dp_cmd.mac = MAC_X1;
          KW'(2):  dp_cmd.mac = MAC_X2;
          KW'(3):  dp_cmd.mac = MAC_X3;
          KW'(4):  dp_cmd.mac = MAC_X4;
          KW'(5):  dp_cmd.mac = MAC_X5;
          KW'(6):  dp_cmd.mac = MAC_T0;
          KW'(7):  dp_cmd.mac = MAC_T1;
          default: dp_cmd.mac = MAC_T2;
        endcase
      end
      ST_ACC:  dp_cmd.accept   = 1'b1;
      ST_DONE: dp_cmd.res_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/mnfpc_dp.sv =====
// Datapath: mesh memories, config registers, shared MAC and result register.
module mnfpc_dp
  import mnfpc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_FACES    = MAX_FACES_DEF,
  parameter int MAX_CORNERS  = MAX_CORNERS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFGIW-1:0]         cfg_index,
  input  logic [CFGW-1:0]          cfg_data,
  input  logic [IDXW-1:0]          entry,
  input  logic [CORNW-1:0]         corner,
  input  logic [IDXW-1:0]          corner_vertex,
  input  logic [SIZEW-1:0]         face_size,
  input  logic signed [COORDW-1:0] pos_x,
  input  logic signed [COORDW-1:0] pos_y,
  input  logic signed [COORDW-1:0] pos_z,
  input  logic signed [COORDW-1:0] normal_x,
  input  logic signed [COORDW-1:0] normal_y,
  input  logic signed [COORDW-1:0] normal_z,
  input  logic [COLW-1:0]          colour_rgb,
  input  dp_cmd_t                  dp_cmd,
  output dp_stat_t                 stat,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     hit,
  output logic [7:0]               red,
  output logic [7:0]               green,
  output logic [7:0]               blue
);

  localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int FAW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int CD  = MAX_FACES * MAX_CORNERS;
  localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
  localparam int VW  = 6 * COORDW + COLW;

  // config
  logic [FCW-1:0]  face_count;
  logic [LIMW-1:0] max_in, max_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_count <= '0;
      max_in     <= LIMW'(2458);
      max_out    <= LIMW'(819);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FACE_COUNT:  face_count <= cfg_data[FCW-1:0];
        CFG_MAX_INSIDE:  max_in     <= cfg_data[LIMW-1:0];
        CFG_MAX_OUTSIDE: max_out    <= cfg_data[LIMW-1:0];
        default: ;
      endcase
    end
  end

  // memories
  logic            v_we, c_we;
  logic [VW-1:0]   v_rdata;
  logic [IDXW-1:0] c_rdata;
  logic [SIZEW-1:0] s_rdata;
  logic            vbad;

  assign v_we = dp_cmd.wr_vertex && (32'(entry) < MAX_VERTICES);
  assign c_we = dp_cmd.wr_corner && (32'(entry) < MAX_FACES) && (32'(corner) < MAX_CORNERS);

  mnfpc_ram #(.W(VW), .D(MAX_VERTICES)) u_vtx (
    .clk   (clk),
    .we    (v_we),
    .waddr (VAW'(entry)),
    .wdata ({pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, colour_rgb}),
    .raddr (VAW'(c_rdata)),
    .rdata (v_rdata)
  );

  mnfpc_ram #(.W(IDXW), .D(CD)) u_corner (
    .clk   (clk),
    .we    (c_we),
    .waddr (CAW'(32'(entry) * MAX_CORNERS + 32'(corner))),
    .wdata (corner_vertex),
    .raddr (CAW'(32'(dp_cmd.face) * MAX_CORNERS + 32'(dp_cmd.corner_idx))),
    .rdata (c_rdata)
  );

  mnfpc_ram #(.W(SIZEW), .D(MAX_FACES)) u_size (
    .clk   (clk),
    .we    (c_we),
    .waddr (FAW'(entry)),
    .wdata (face_size),
    .raddr (FAW'(dp_cmd.face)),
    .rdata (s_rdata)
  );

  // out-of-range vertex index reads as all zero
  always_ff @(posedge clk) begin
    vbad <= (32'(c_rdata) >= MAX_VERTICES);
  end

  logic [VW-1:0] vtx;
  logic signed [COORDW-1:0] vpos [3];
  logic signed [COORDW-1:0] vnrm [3];
  logic [COLW-1:0] vcol;

  always_comb begin
    vtx     = vbad ? '0 : v_rdata;
    vpos[0] = vtx[VW-1 -: COORDW];
    vpos[1] = vtx[VW-1-COORDW -: COORDW];
    vpos[2] = vtx[VW-1-2*COORDW -: COORDW];
    vnrm[0] = vtx[VW-1-3*COORDW -: COORDW];
    vnrm[1] = vtx[VW-1-4*COORDW -: COORDW];
    vnrm[2] = vtx[VW-1-5*COORDW -: COORDW];
    vcol    = vtx[COLW-1:0];
  end

  // vector registers
  logic signed [COORDW-1:0] q [3];
  logic signed [COORDW-1:0] u1 [3];
  logic signed [COORDW-1:0] u2 [3];
  logic signed [COORDW-1:0] nm [3];
  logic [COLW-1:0] col0;

  always_ff @(posedge clk) begin
    if (dp_cmd.q_load) begin
      q[0] <= pos_x;
      q[1] <= pos_y;
      q[2] <= pos_z;
    end
    if (dp_cmd.load_p) begin
      u2   <= vpos;
      nm   <= vnrm;
      col0 <= vcol;
    end
    if (dp_cmd.load_u2) u2 <= vpos;
    if (dp_cmd.load_edge) begin
      u1 <= u2;
      u2 <= vpos;
    end
  end

  // differences
  logic signed [COORDW:0] dq [3];  // q - u1
  logic signed [COORDW:0] dv [3];  // q - u2 (plane point)
  logic signed [COORDW:0] e  [3];  // u2 - u1

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dq[j] = {q[j][COORDW-1], q[j]} - {u1[j][COORDW-1], u1[j]};
      dv[j] = {q[j][COORDW-1], q[j]} - {u2[j][COORDW-1], u2[j]};
      e[j]  = {u2[j][COORDW-1], u2[j]} - {u1[j][COORDW-1], u1[j]};
    end
  end

  // shared multiply-accumulate
  logic signed [WW-1:0]    w0, w1, w2;
  logic signed [ACCW-1:0]  acc;
  logic signed [OPAW-1:0]  op_a;
  logic signed [OPBW-1:0]  op_b;
  logic signed [PRODW-1:0] prod;
  logic                    mac_load, mac_sub;

  always_comb begin
    op_a     = '0;
    op_b     = '0;
    mac_load = 1'b0;
    mac_sub  = 1'b0;
    unique case (dp_cmd.mac)
      MAC_D0: begin op_a = OPAW'(dv[0]); op_b = OPBW'(nm[0]); mac_load = 1'b1; end
      MAC_D1: begin op_a = OPAW'(dv[1]); op_b = OPBW'(nm[1]); end
      MAC_D2: begin op_a = OPAW'(dv[2]); op_b = OPBW'(nm[2]); end
      MAC_X0: begin op_a = OPAW'(dq[1]); op_b = OPBW'(e[2]); mac_load = 1'b1; end
      MAC_X1: begin op_a = OPAW'(dq[2]); op_b = OPBW'(e[1]); mac_sub = 1'b1; end
      MAC_X2: begin op_a = OPAW'(dq[2]); op_b = OPBW'(e[0]); mac_load = 1'b1; end
      MAC_X3: begin op_a = OPAW'(dq[0]); op_b = OPBW'(e[2]); mac_sub = 1'b1; end
      MAC_X4: begin op_a = OPAW'(dq[0]); op_b = OPBW'(e[1]); mac_load = 1'b1; end
      MAC_X5: begin op_a = OPAW'(dq[1]); op_b = OPBW'(e[0]); mac_sub = 1'b1; end
      MAC_T0: begin op_a = OPAW'(nm[0]); op_b = OPBW'(w0); mac_load = 1'b1; end
      MAC_T1: begin op_a = OPAW'(nm[1]); op_b = OPBW'(w1); end
      MAC_T2: begin op_a = OPAW'(nm[2]); op_b = OPBW'(w2); end
      default: ;
    endcase
    prod = op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.mac != MAC_NONE) begin
      if (mac_load)     acc <= ACCW'(prod);
      else if (mac_sub) acc <= acc - ACCW'(prod);
      else              acc <= acc + ACCW'(prod);
    end
    // cross-product terms are complete when the next term starts
    if (dp_cmd.mac == MAC_X2) w0 <= acc[WW-1:0];
    if (dp_cmd.mac == MAC_X4) w1 <= acc[WW-1:0];
    if (dp_cmd.mac == MAC_T0) w2 <= acc[WW-1:0];
  end

  // distance and edge checks
  logic                   acc_neg;
  logic [ACCW-1:0]        acc_abs;
  logic [ABSW-1:0]        abs_s, cur_abs, best;
  logic                   found;
  logic [COLW-1:0]        best_col;

  always_comb begin
    acc_neg  = acc[ACCW-1];
    acc_abs  = acc_neg ? ACCW'(-acc) : ACCW'(acc);
    abs_s    = acc_abs[ABSW-1:0];
    stat.dist_ok = !(acc_neg && (abs_s > ABSW'({max_in, 14'b0})))
                && !(!acc_neg && (abs_s > ABSW'({max_out, 14'b0})))
                && !(found && (abs_s > best));
    stat.edge_out = !acc_neg && (acc != '0);
    stat.size     = s_rdata;
    stat.count    = (32'(face_count) > MAX_FACES) ? FCW'(MAX_FACES) : face_count;
    stat.out_free = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.dist_chk) cur_abs <= abs_s;
    if (dp_cmd.accept) begin
      best     <= cur_abs;
      best_col <= col0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (dp_cmd.q_load)      found <= 1'b0;
      else if (dp_cmd.accept) found <= 1'b1;
      if (dp_cmd.res_load)                out_valid <= 1'b1;
      else if (out_valid && !out_stall)   out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.res_load) begin
      hit   <= found;
      red   <= found ? best_col[23:16] : 8'd0;
      green <= found ? best_col[15:8]  : 8'd0;
      blue  <= found ? best_col[7:0]   : 8'd0;
    end
  end

endmodule
